// ===== hdl/pixel_darken_scaler_top_macros.svh =====
// Assertion macros for the pixel darken scaler.
// Used by pixel_darken_scaler_top; needs nothing else.
`ifndef PIXEL_DARKEN_SCALER_TOP_MACROS_SVH
`define PIXEL_DARKEN_SCALER_TOP_MACROS_SVH

// same-cycle implication
`define PDSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pdsc_pkg.sv =====
// Shared types and constants for the pixel darken scaler.
// No dependencies.
`default_nettype none

package pdsc_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int PIX_W   = 24;
  localparam int LEVEL_W = 10;
  localparam int SCALE_W = 9;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = SCALE_W + QUO_W;
  localparam int PROD_W  = 8 + QUO_W;
  localparam int RECIP_W = 15;
  localparam int RP_W    = 14 + RECIP_W;

  // restoring divider: bits per stage and stage count
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // pipeline stage indexes
  localparam int ST_DEC      = 0;
  localparam int ST_MUL      = 1;
  localparam int ST_DIV0     = 2;
  localparam int ST_DIV_LAST = ST_DIV0 + DIV_STAGES - 1;
  localparam int ST_CHMUL    = ST_DIV_LAST + 1;
  localparam int ST_CHDIV    = ST_CHMUL + 1;
  localparam int ST_OUT      = ST_CHDIV + 1;
  localparam int NUM_STAGES  = ST_OUT + 1;

  // pixel format codes
  localparam logic [1:0] FMT_RGB888 = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_RGB555 = 2'd2;

  localparam logic [QUO_W-1:0] FULL_888 = 15'd32767;
  localparam logic [QUO_W-1:0] FULL_16  = 15'd255;

  // x / d == (x * RECIP) >> SH for the product ranges seen here
  localparam logic [RECIP_W-1:0] RECIP_31 = 15'd8457;
  localparam int                 SH_31    = 18;
  localparam logic [RECIP_W-1:0] RECIP_63 = 15'd16645;
  localparam int                 SH_63    = 20;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_ORDER  = 2'd1,
    REG_FLOOR  = 2'd2,
    REG_SCALE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         pixel_format;
    logic               byte_order_big;
    logic [QUO_W-1:0]   darkness_floor;
    logic [SCALE_W-1:0] level_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pixel_format:   FMT_RGB888,
    byte_order_big: 1'b0,
    darkness_floor: 15'd0,
    level_scale:    9'd16
  };

endpackage

`default_nettype wire

// ===== hdl/pdsc_div.sv =====
// Pipelined restoring divider for the brightness factor, DIV_BITS per stage.
// Depends on pdsc_pkg.
`default_nettype none

module pdsc_div (
  input  logic                              clk,
  input  logic [pdsc_pkg::DIV_STAGES-1:0]   en,
  input  logic [pdsc_pkg::NUM_W-1:0]        num,
  input  logic [pdsc_pkg::SCALE_W-1:0]      sc,
  output logic [pdsc_pkg::QUO_W-1:0]        quo
);
  import pdsc_pkg::*;

  // rem < sc always; low holds unconsumed dividend bits, quotient shifts in
  logic [SCALE_W-1:0] rem [DIV_STAGES];
  logic [QUO_W-1:0]   low [DIV_STAGES];
  logic [NUM_W-1:0]   nxt [DIV_STAGES];

  function automatic logic [NUM_W-1:0] div_steps(input logic [SCALE_W-1:0] r_in,
                                                 input logic [QUO_W-1:0]   l_in,
                                                 input logic [SCALE_W-1:0] d);
    logic [SCALE_W-1:0] r;
    logic [QUO_W-1:0]   l;
    logic [SCALE_W:0]   t;
    logic               qb;
    r = r_in;
    l = l_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {r, l[QUO_W-1]};
      qb = (t >= {1'b0, d});
      if (qb) begin
        t = t - {1'b0, d};
      end
      r = t[SCALE_W-1:0];
      l = {l[QUO_W-2:0], qb};
    end
    return {r, l};
  endfunction

  always_comb begin
    nxt[0] = div_steps(num[NUM_W-1:QUO_W], num[QUO_W-1:0], sc);
    for (int k = 1; k < DIV_STAGES; k++) begin
      nxt[k] = div_steps(rem[k-1], low[k-1], sc);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        rem[k] <= nxt[k][NUM_W-1:QUO_W];
        low[k] <= nxt[k][QUO_W-1:0];
      end
    end
  end

  assign quo = low[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/pdsc_cfg.sv =====
// APB register file holding the scaler configuration.
// Depends on pdsc_pkg.
`default_nettype none

module pdsc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pdsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [pdsc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output pdsc_pkg::cfg_t                cfg
);
  import pdsc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_FORMAT: cfg.pixel_format   <= pwdata[1:0];
        REG_ORDER:  cfg.byte_order_big <= pwdata[0];
        REG_FLOOR:  cfg.darkness_floor <= pwdata[QUO_W-1:0];
        REG_SCALE:  cfg.level_scale    <= pwdata[SCALE_W-1:0];
        default:    cfg                <= cfg;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_FORMAT: prdata[1:0]         = cfg.pixel_format;
      REG_ORDER:  prdata[0]           = cfg.byte_order_big;
      REG_FLOOR:  prdata[QUO_W-1:0]   = cfg.darkness_floor;
      REG_SCALE:  prdata[SCALE_W-1:0] = cfg.level_scale;
      default:    prdata              = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pixel_darken_scaler_top.sv =====
// Pixel darken scaler: scales the color channels of one pixel word by a level factor.
// One word per cycle sustained while the result side does not stall.
// Throughput is set by the five-stage restoring divider and the channel multipliers,
// all fully pipelined. Stalls back up stage by stage; bubbles collapse.
// Synchronous reset clears valid bits and the config registers; no clearing pass.
// Depends on pdsc_pkg, pdsc_div, pdsc_cfg and pixel_darken_scaler_top_macros.svh.
`default_nettype none

module pixel_darken_scaler_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pdsc_pkg::PADDR_W-1:0]         paddr,
  input  logic [pdsc_pkg::PDATA_W-1:0]         pwdata,
  output logic [pdsc_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  // pixel word in
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  logic [pdsc_pkg::PIX_W-1:0]           pixel_in,
  input  logic signed [pdsc_pkg::LEVEL_W-1:0]  level,
  // result word out
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [pdsc_pkg::PIX_W-1:0]           pixel_out
);
  import pdsc_pkg::*;
  `include "pixel_darken_scaler_top_macros.svh"

  cfg_t cfg;

  // stage handshake: rdy[s] means stage s can load this cycle
  logic [NUM_STAGES-1:0] v, rdy, src_v, en;

  // sideband that travels through every stage
  logic [PIX_W-1:0]      pix_q [NUM_STAGES];
  logic [NUM_STAGES-1:0] neg_q;

  // config-derived values; the user keeps them static while words are in flight, the block does not enforce it
  logic [SCALE_W-1:0] sc;
  logic [QUO_W-1:0]   full_c, floor_c, span_c;

  logic [SCALE_W-1:0] lvl_in, lvl_c, lvl_q;
  logic [NUM_W-1:0]   num_q;
  logic [QUO_W-1:0]   quo, fac;

  logic [PIX_W-1:0]   ps_m, ps_o;
  logic [7:0]         lo_m, hi_m, lo_o, hi_o, lo_p, hi_p;
  logic [7:0]         ch     [3];
  logic [PROD_W-1:0]  prod_q [3];
  logic [7:0]         q0     [3];
  logic [QUO_W:0]     rsum   [3];
  logic [7:0]         d888   [3];
  logic [RP_W-1:0]    rp     [3];
  logic [7:0]         d888_q [3];
  logic [RP_W-1:0]    rp_q   [3];
  logic [7:0]         dch    [3];
  logic [PIX_W-1:0]   res_c, out_q;

  pdsc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  always_comb begin
    src_v[ST_DEC] = pix_valid;
    for (int s = 1; s < NUM_STAGES; s++) begin
      src_v[s] = v[s-1];
    end
    rdy[ST_OUT] = !v[ST_OUT] || !res_stall;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
    en = rdy & src_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (rdy[s]) begin
          v[s] <= src_v[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_DEC]) begin
      pix_q[ST_DEC] <= pixel_in;
      neg_q[ST_DEC] <= level[LEVEL_W-1];
    end
    for (int s = 1; s < NUM_STAGES; s++) begin
      if (en[s]) begin
        pix_q[s] <= pix_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign pix_stall = !rdy[ST_DEC];
  assign res_valid = v[ST_OUT];
  assign pixel_out = out_q;

  // ---------------------------------------------------------------------------
  // Factor: floor + lvl * (full - floor) / scale
  // ---------------------------------------------------------------------------
  always_comb begin
    sc      = (cfg.level_scale == '0) ? SCALE_W'(1) : cfg.level_scale;
    full_c  = (cfg.pixel_format == FMT_RGB888) ? FULL_888 : FULL_16;
    floor_c = (cfg.darkness_floor > full_c) ? full_c : cfg.darkness_floor;
    span_c  = full_c - floor_c;
    lvl_in  = level[SCALE_W-1:0];
    lvl_c   = (lvl_in > sc) ? sc : lvl_in;
  end

  // decode stage: clamp the level
  always_ff @(posedge clk) begin
    if (en[ST_DEC]) begin
      lvl_q <= lvl_c;
    end
  end

  // numerator; stays below sc << QUO_W so the quotient fits QUO_W bits
  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      num_q <= NUM_W'(lvl_q) * NUM_W'(span_c);
    end
  end

  pdsc_div u_div (
    .clk (clk),
    .en  (en[ST_DIV_LAST:ST_DIV0]),
    .num (num_q),
    .sc  (sc),
    .quo (quo)
  );

  // ---------------------------------------------------------------------------
  // Channel multiply: ch0 = blue/byte0, ch1 = green/byte1, ch2 = red/byte2
  // ---------------------------------------------------------------------------
  assign fac  = floor_c + quo;
  assign ps_m = pix_q[ST_DIV_LAST];
  assign lo_m = cfg.byte_order_big ? ps_m[15:8] : ps_m[7:0];
  assign hi_m = cfg.byte_order_big ? ps_m[7:0]  : ps_m[15:8];

  always_comb begin
    case (cfg.pixel_format)
      FMT_RGB565: begin
        ch[0] = {3'b000, lo_m[4:0]};
        ch[1] = {2'b00, hi_m[2:0], lo_m[7:5]};
        ch[2] = {3'b000, hi_m[7:3]};
      end
      FMT_RGB555: begin
        // top bit of the high byte is ignored
        ch[0] = {3'b000, lo_m[4:0]};
        ch[1] = {3'b000, hi_m[1:0], lo_m[7:5]};
        ch[2] = {3'b000, hi_m[6:2]};
      end
      default: begin
        ch[0] = ps_m[7:0];
        ch[1] = ps_m[15:8];
        ch[2] = ps_m[23:16];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_CHMUL]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= PROD_W'(ch[i]) * PROD_W'(fac);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel divide.
  // 24-bit: p / 32767 = (p >> 15) + one correction, since p = q*32767 + (lo + q).
  // 15/16-bit: products stay below 2^14, reciprocal multiply by 1/31 or 1/63.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q0[i]   = prod_q[i][PROD_W-1:QUO_W];
      rsum[i] = {1'b0, prod_q[i][QUO_W-1:0]} + (QUO_W+1)'(q0[i]);
      d888[i] = q0[i] + 8'(rsum[i] >= {1'b0, FULL_888});
      if (cfg.pixel_format == FMT_RGB565 && i == 1) begin
        rp[i] = RP_W'(prod_q[i][13:0]) * RP_W'(RECIP_63);
      end else begin
        rp[i] = RP_W'(prod_q[i][13:0]) * RP_W'(RECIP_31);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CHDIV]) begin
      for (int i = 0; i < 3; i++) begin
        d888_q[i] <= d888[i];
        rp_q[i]   <= rp[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Repack into the input layout; negative level passes the bytes through
  // ---------------------------------------------------------------------------
  assign ps_o = pix_q[ST_CHDIV];
  assign lo_o = cfg.byte_order_big ? ps_o[15:8] : ps_o[7:0];
  assign hi_o = cfg.byte_order_big ? ps_o[7:0]  : ps_o[15:8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg.pixel_format == FMT_RGB565 && i == 1) begin
        dch[i] = rp_q[i][SH_63 +: 8];
      end else begin
        dch[i] = rp_q[i][SH_31 +: 8];
      end
    end

    if (cfg.pixel_format == FMT_RGB565) begin
      lo_p = {dch[1][4:2], dch[0][7:3]};
      hi_p = {dch[2][7:3], dch[1][7:5]};
    end else begin
      lo_p = {dch[1][5:3], dch[0][7:3]};
      hi_p = {1'b0, dch[2][7:3], dch[1][7:6]};
    end
    if (neg_q[ST_CHDIV]) begin
      lo_p = lo_o;
      hi_p = hi_o;
    end

    case (cfg.pixel_format) inside
      FMT_RGB888: begin
        res_c = neg_q[ST_CHDIV] ? ps_o : {d888_q[2], d888_q[1], d888_q[0]};
      end
      FMT_RGB565, FMT_RGB555: begin
        res_c = cfg.byte_order_big ? {8'h00, lo_p, hi_p} : {8'h00, hi_p, lo_p};
      end
      default: begin
        res_c = ps_o;
      end
    endcase
  end

  // output register; holds while the downstream side stalls
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_q <= res_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PDSC_ASSERT_NEXT(a_enter, clk, rst, pix_valid && !pix_stall, v[ST_DEC], "accepted word lost at entry")
  `PDSC_ASSERT_NOW(a_full_stall, clk, rst, (&v) && res_stall, pix_stall, "input taken while pipeline full and stalled")
  `PDSC_ASSERT_NOW(a_darker, clk, rst, v[ST_OUT] && !neg_q[ST_OUT] && cfg.pixel_format == FMT_RGB888, out_q[7:0] <= pix_q[ST_OUT][7:0] && out_q[15:8] <= pix_q[ST_OUT][15:8] && out_q[23:16] <= pix_q[ST_OUT][23:16], "24-bit channel brighter than input")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for pixel_darken_scaler_top: directed and random pixel words
// in all three formats, checked against an in-bench predictor. Needs pdsc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import pdsc_pkg::*;

  // Latency of the block, padded a little for drains.
  localparam int LATENCY     = 10;
  localparam int DRAIN_PAD   = LATENCY + 4;
  localparam int HOLD_CYCLES = 120;     // long output hold, well past the pipeline depth
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int RAND_WORDS  = 144;     // per phase, about 1150 in all
  localparam int MAX_PRINTS  = 20;

  typedef struct {
    logic [PIX_W-1:0]          pix;
    logic signed [LEVEL_W-1:0] lvl;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // config port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // word channels
  logic                      pix_valid = 1'b0;
  logic                      pix_stall;
  logic [PIX_W-1:0]          pixel_in  = '0;
  logic signed [LEVEL_W-1:0] level     = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [PIX_W-1:0]          pixel_out;

  // shadow of the block's registers, written together with the port writes
  cfg_t dut_cfg = CFG_RESET;

  pixel_word_t      pending_words[$];    // words not yet offered to the block
  logic [PIX_W-1:0] expected_pixels[$];  // darkened pixels owed by the block

  int  send_idle_pct = 35;
  int  recv_idle_pct = 58;
  int  hold_ask      = 0;   // bumped by the stimulus to request one long hold
  int  hold_seen     = 0;
  int  hold_left     = 0;
  int  words_in      = 0;
  int  words_out     = 0;
  int  n_fail        = 0;
  int  n_settings    = 1;   // reset setting counts as one
  int  cycle_count   = 0;
  bit  word_taken    = 1'b0;

  pixel_darken_scaler_top uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pixel_in  (pixel_in),
    .level     (level),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .pixel_out (pixel_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Brightness factor: floor plus the level's share of the span up to full.
  // Level clamps to the scale, floor clamps to full, a zero scale acts as one.
  function automatic int unsigned level_factor(int unsigned lvl, int unsigned full,
                                               int unsigned flr, int unsigned scl);
    int unsigned sc;
    sc = (scl == 0) ? 1 : scl;
    if (flr > full) flr = full;
    if (lvl > sc) lvl = sc;
    return flr + (lvl * (full - flr)) / sc;
  endfunction

  // Expected output word for one input word under register setting c.
  function automatic logic [PIX_W-1:0] darkened_pixel(cfg_t c, logic [PIX_W-1:0] pix,
                                                      logic signed [LEVEL_W-1:0] lvl_in);
    int unsigned      lvl, f, lo, hi, r, g, b;
    logic             neg;
    logic [PIX_W-1:0] res;
    neg = lvl_in[LEVEL_W-1];
    lvl = lvl_in[LEVEL_W-2:0];
    res = pix;
    case (c.pixel_format) inside
      FMT_RGB888: begin
        if (!neg) begin
          f = level_factor(lvl, FULL_888, c.darkness_floor, c.level_scale);
          r = (int'(pix[7:0]) * f) / FULL_888;
          g = (int'(pix[15:8]) * f) / FULL_888;
          b = (int'(pix[23:16]) * f) / FULL_888;
          res = {8'(b), 8'(g), 8'(r)};
        end
      end
      FMT_RGB565, FMT_RGB555: begin
        // big endian keeps the high byte in bits 7:0
        lo = c.byte_order_big ? pix[15:8] : pix[7:0];
        hi = c.byte_order_big ? pix[7:0] : pix[15:8];
        if (!neg) begin
          f = level_factor(lvl, FULL_16, c.darkness_floor, c.level_scale);
          if (c.pixel_format == FMT_RGB565) begin
            r = hi >> 3;
            g = ((hi & 7) << 3) | (lo >> 5);
            b = lo & 31;
            r = ((r * f) / 31) & 255;
            g = ((g * f) / 63) & 255;
            b = ((b * f) / 31) & 255;
            lo = ((b & 248) >> 3) | ((g & 28) << 3);
            hi = ((g & 224) >> 5) | (r & 248);
          end else begin
            // top bit of the high byte is dropped on the way in
            r = (hi >> 2) & 31;
            g = ((hi & 3) << 3) | (lo >> 5);
            b = lo & 31;
            r = ((r * f) / 31) & 255;
            g = ((g * f) / 31) & 255;
            b = ((b * f) / 31) & 255;
            lo = ((b & 248) >> 3) | ((g & 56) << 2);
            hi = ((g & 192) >> 6) | ((r & 248) >> 1);
          end
        end
        res = c.byte_order_big ? {8'h00, 8'(lo), 8'(hi)} : {8'h00, 8'(hi), 8'(lo)};
      end
      default: res = pix;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    n_fail++;
    if (n_fail <= MAX_PRINTS)
      $display("ERROR at %0t: %s: expected %06h got %06h", $time, what, want, got);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_registers(logic [1:0] fmt, logic order, logic [QUO_W-1:0] flr,
                               logic [SCALE_W-1:0] scl);
    write_reg(REG_FORMAT, PDATA_W'(fmt));
    write_reg(REG_ORDER,  PDATA_W'(order));
    write_reg(REG_FLOOR,  PDATA_W'(flr));
    write_reg(REG_SCALE,  PDATA_W'(scl));
    dut_cfg = '{pixel_format: fmt, byte_order_big: order, darkness_floor: flr,
                level_scale: scl};
    n_settings++;
  endtask

  task automatic push_word(logic [PIX_W-1:0] pix, logic signed [LEVEL_W-1:0] lvl);
    pixel_word_t w;
    w.pix = pix;
    w.lvl = lvl;
    pending_words.push_back(w);
  endtask

  // Registers may only change with the block empty: everything offered,
  // everything returned, then a latency's worth of quiet.
  task automatic wait_drained();
    while (pending_words.size() != 0 || pix_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Random words: mostly in-range levels, with extra weight on pass-through,
  // zero, the scale itself and 256, the largest scale.
  task automatic push_random(int n);
    logic signed [LEVEL_W-1:0] lvl;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       lvl = -10'sd1;
        1:       lvl = 10'sd0;
        2:       lvl = 10'sd256;
        3:       lvl = LEVEL_W'(dut_cfg.level_scale);
        default: lvl = LEVEL_W'($urandom_range(256));
      endcase
      push_word(PIX_W'($urandom()), lvl);
    end
  endtask

  // Cycle watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               expected_pixels.size());
      $display("pixel_darken_scaler_top: mismatch");
      $finish;
    end
  end

  // Long output hold, counted here so the stimulus only has to ask for it.
  always @(posedge clk) begin
    if (hold_left != 0)
      hold_left <= hold_left - 1;
    else if (hold_ask != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_ask;
    end
  end

  // Receiver: random stalls at the current rate, solid stall during a hold.
  always @(negedge clk) begin
    res_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Driver: a new word (or a gap) only once the current one has been taken,
  // so an offered word holds steady while the block stalls it.
  always @(negedge clk) begin : drive_words
    pixel_word_t w;
    if (!pix_valid || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        pix_valid <= 1'b1;
        pixel_in  <= w.pix;
        level     <= w.lvl;
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Monitor: check the outgoing word first, then log the incoming one, so a
  // word accepted this edge can never be matched against a result of this edge.
  always @(posedge clk) begin : watch_words
    logic [PIX_W-1:0] want;
    if (rst) begin
      word_taken = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        words_out++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result word with nothing owed", '0, pixel_out);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want)
            report_mismatch("pixel_out", want, pixel_out);
        end
      end
      word_taken = pix_valid && !pix_stall;
      if (word_taken) begin
        expected_pixels.push_back(darkened_pixel(dut_cfg, pixel_in, level));
        words_in++;
      end
    end
  end

  // Stimulus and run control.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Reset setting first: 24-bit, floor 0, scale 16.
    // Pass-through, zero level, full level, level far above the scale.
    push_word(24'hFFFFFF, -10'sd1);
    push_word(24'hFFFFFF, 10'sd0);
    push_word(24'hFFFFFF, 10'sd16);
    push_word(24'hFFFFFF, 10'sd256);
    push_word(24'h000000, 10'sd256);
    push_word(24'h123456, 10'sd8);
    wait_drained();

    // 565 little endian; floor above 255 must clamp; junk in bits 23:16 must vanish.
    set_registers(FMT_RGB565, 1'b0, 15'd300, 9'd8);
    push_word(24'hAAFFFF, -10'sd1);
    push_word(24'h00FFFF, 10'sd0);
    push_word(24'hFFFFFF, 10'sd4);
    push_word(24'h00F800, 10'sd8);
    push_word(24'h0007E0, 10'sd3);
    push_word(24'h00001F, 10'sd256);
    push_word(24'h55ABCD, 10'sd5);
    wait_drained();

    // 555 big endian: top bit of the high byte (bits 7:0 here) is ignored.
    set_registers(FMT_RGB555, 1'b1, 15'd0, 9'd256);
    push_word(24'h00FFFF, -10'sd1);
    push_word(24'h00FFFF, 10'sd256);
    push_word(24'h000080, 10'sd256);
    push_word(24'hFFFF7F, 10'sd100);
    push_word(24'h00FF80, 10'sd0);
    push_word(24'h00007C, 10'sd200);
    push_word(24'h0003E0, 10'sd255);
    wait_drained();

    // 24-bit at the top of the floor range and the smallest scale.
    set_registers(FMT_RGB888, 1'b0, 15'd32767, 9'd1);
    push_word(24'hFFFFFF, 10'sd0);
    push_word(24'hA5A5A5, 10'sd1);
    push_word(24'h010203, 10'sd256);
    push_word(24'hFFFFFF, -10'sd1);
    wait_drained();

    // Random part: register extremes plus random settings, idling rates
    // swapped a third of the way through and dropped for the last stretch.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 58;
      end else if (ph < 6) begin
        send_idle_pct = 58;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_registers(FMT_RGB888, 1'b0, 15'd0, 9'd256);
        1: set_registers(FMT_RGB565, 1'b0, 15'd32767, 9'd1);
        2: set_registers(FMT_RGB555, 1'b1, 15'($urandom()), 9'($urandom_range(256, 1)));
        3: set_registers(FMT_RGB565, 1'b1, 15'd255, 9'd256);
        4: set_registers(FMT_RGB888, 1'b1, 15'd32767, 9'd1);
        5: set_registers(FMT_RGB555, 1'b0, 15'd0, 9'($urandom_range(256, 1)));
        6: set_registers(FMT_RGB888, 1'($urandom()), 15'($urandom()),
                         9'($urandom_range(256, 1)));
        default: set_registers($urandom_range(1) ? FMT_RGB565 : FMT_RGB555, 1'($urandom()),
                               15'($urandom_range(255)), 9'($urandom_range(256, 1)));
      endcase
      push_random(RAND_WORDS);
      // First random phase: hold the output long enough to fill the pipe
      // and push stall back to the sender.
      if (ph == 0) begin
        @(negedge clk);
        hold_ask++;
      end
      wait_drained();
    end

    if (expected_pixels.size() != 0)
      report_mismatch("pixel never returned", expected_pixels[0], 'x);

    $display("covered %0d pixel words in and %0d out over %0d register settings,",
             words_in, words_out, n_settings);
    $display("three formats, both byte orders, level clamps, idling and a long hold");
    if (n_fail == 0) begin
      $display("pixel_darken_scaler_top: match");
    end else begin
      $display("%0d failures", n_fail);
      $display("pixel_darken_scaler_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pdsc_pkg.sv
hdl/pdsc_div.sv
hdl/pdsc_cfg.sv
hdl/pixel_darken_scaler_top.sv
tb/sv/testbench.sv
